// ===== rtl/spectrum_band_energy_unit_macros.svh =====
// Assertion helpers for the band energy unit; clk and rst_n come from the
// module that uses them.
`ifndef SPECTRUM_BAND_ENERGY_UNIT_MACROS_SVH
`define SPECTRUM_BAND_ENERGY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SBE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbe assertion failed");
`define SBE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbe assertion failed");
`else
`define SBE_ASSERT_IMP(name, ante, cons)
`define SBE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/sbe_pkg.sv =====
`timescale 1ns / 1ps
package sbe_pkg;

  localparam int BANDS  = 4;
  localparam int EDGES  = 5;
  localparam int EDGE_W = 12;
  localparam int MAG_W  = 16;
  localparam int HZ_W   = 32;
  localparam int MEAN_W = 32;
  localparam int DB_W   = 16;
  localparam int SUM_W  = 48;
  localparam int RAT_W  = 21;
  localparam int F_W    = 22;
  localparam int F2_W   = 44;
  localparam int DEN_W  = 45;
  localparam int REM_W  = 46;
  localparam int DVD_W  = 48;
  localparam int SQ_W   = 40;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;

  localparam logic [F_W-1:0]   FREQ_MAX   = 22'h3FFFFF;
  localparam logic [DEN_W-1:0] KA2        = 45'd108636;
  localparam logic [DEN_W-1:0] KB2        = 45'd2969418;
  localparam logic [DEN_W-1:0] KD2        = 45'd139391081;
  localparam logic [DEN_W-1:0] KC2        = 45'd38066925630;
  localparam logic [25:0]      DB_K       = 26'd50504462;
  localparam logic signed [16:0] DB_OFFSET = 17'sd12330;
  localparam logic signed [16:0] DB_FLOOR  = -17'sd25600;
  localparam logic signed [16:0] DB_CEIL   = 17'sd25600;
  localparam logic [5:0]       RAT_STEPS  = 6'd21;
  localparam logic [5:0]       MEAN_STEPS = 6'd48;

  typedef enum logic [2:0] {
    REG_EDGE_LOW      = 3'd0,
    REG_EDGE_LOW_MID  = 3'd1,
    REG_EDGE_MID_HIGH = 3'd2,
    REG_EDGE_HIGH     = 3'd3,
    REG_EDGE_TOP      = 3'd4,
    REG_WEIGHTING_ON  = 3'd5,
    REG_HZ_PER_BIN    = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_FREQ, ST_FSQ, ST_F2, ST_DSTART, ST_DWAIT,
    ST_SQMUL, ST_SQSTART, ST_SQWAIT, ST_G1, ST_G2, ST_G3, ST_WSEL, ST_PSQ,
    ST_ACC, ST_CSEL, ST_CWAIT, ST_NINIT, ST_NORM, ST_LSQ, ST_LUPD, ST_DBMUL,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_FREQ, MUL_FSQ, MUL_RBRD, MUL_RAS, MUL_GRC, MUL_MAGG,
    MUL_WSQ, MUL_LOG, MUL_DB
  } mul_sel_t;

  typedef enum logic [2:0] {
    DIV_RA, DIV_RB, DIV_RD, DIV_RC, DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    logic      accept;
    mul_sel_t  mul_sel;
    logic      f2_load;
    logic      div_start;
    div_sel_t  div_sel;
    logic      div_store;
    logic      sq_start;
    logic      wm_load;
    logic      wm_raw;
    logic      acc;
    logic      mean_load;
    logic      mean_clear;
    logic      norm_init;
    logic      norm_step;
    logic      log_step;
    logic      emit;
    logic      spec_clear;
    logic [1:0] band;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic weight_en;
    logic last_bin;
    logic div_busy;
    logic sq_busy;
    logic cnt_zero;
    logic mean_zero;
    logic y_msb;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/sbe_if.sv =====
`timescale 1ns / 1ps
interface sbe_in_if;
  import sbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             last_bin;
  modport source (output valid, magnitude, last_bin, input ready);
  modport sink   (input valid, magnitude, last_bin, output ready);
endinterface

interface sbe_out_if;
  import sbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        band_index;
  logic [MEAN_W-1:0] mean_power;
  logic signed [DB_W-1:0] power_db;
  logic              last_band;
  modport source (output valid, band_index, mean_power, power_db, last_band,
                  input ready);
  modport sink   (input valid, band_index, mean_power, power_db, last_band,
                  output ready);
endinterface

// ===== rtl/sbe_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The partial remainder is
// preloaded and further dividend bits shift in from shin.
module sbe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [sbe_pkg::REM_W-1:0] rem_i,
  input  logic [sbe_pkg::DVD_W-1:0] shin_i,
  input  logic [sbe_pkg::DEN_W-1:0] den_i,
  input  logic [5:0]                steps_i,
  output logic                      busy_o,
  output logic [sbe_pkg::DVD_W-1:0] quot_o
);
  import sbe_pkg::*;

  logic [REM_W-1:0] rem_r;
  logic [DVD_W-1:0] shin_r;
  logic [DEN_W-1:0] den_r;
  logic [DVD_W-1:0] quot_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             ge;
  logic [REM_W-1:0] remv;

  assign ge   = rem_r >= {1'b0, den_r};
  assign remv = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= steps_i;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= rem_i;
      shin_r <= shin_i;
      den_r  <= den_i;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= {remv[REM_W-2:0], shin_r[DVD_W-1]};
      shin_r <= {shin_r[DVD_W-2:0], 1'b0};
      quot_r <= {quot_r[DVD_W-2:0], ge};
    end
  end

  assign busy_o = busy_r;
  assign quot_o = quot_r;
endmodule

// ===== rtl/sbe_dp.sv =====
`timescale 1ns / 1ps
module sbe_dp #(
  parameter int MAX_BINS = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sbe_pkg::ctrl_cmd_t                         cmd_i,
  output sbe_pkg::dp_status_t                        st_o,
  input  logic [sbe_pkg::MAG_W-1:0]                  in_mag_i,
  input  logic                                       in_last_i,
  input  logic [sbe_pkg::EDGES-1:0][sbe_pkg::EDGE_W-1:0] edges_i,
  input  logic                                       weighting_i,
  input  logic [sbe_pkg::HZ_W-1:0]                   hz_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [1:0]                                 out_band_o,
  output logic [sbe_pkg::MEAN_W-1:0]                 out_mean_o,
  output logic signed [sbe_pkg::DB_W-1:0]            out_db_o,
  output logic                                       out_last_o
);
  import sbe_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int BP_W  = $clog2(MAX_BINS + 1);
  localparam int CMP_W = (IDX_W > EDGE_W) ? IDX_W : EDGE_W;

  // per-bin capture
  logic [MAG_W-1:0] mag_r;
  logic             last_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] fin_r;
  logic             in_range_r;
  logic             weight_r;

  // spectrum state
  logic [BP_W-1:0]   bin_pos_r;
  logic [SUM_W-1:0]  sum_r [BANDS];
  logic [BP_W-1:0]   cnt_r [BANDS];
  logic [MEAN_W-1:0] fbp_r;

  // weighting
  logic [PROD_W-1:0] prod_r;
  logic [F2_W-1:0]   f2_r;
  logic [RAT_W-1:0]  ra_r, rb_r, rd_r, rc_r;
  logic [MAG_W-1:0]  wm_r;
  logic [SQ_W-1:0]   sq_v_r, sq_root_r, sq_bit_r;
  logic              sq_busy_r;

  // close
  logic [MEAN_W-1:0] mean_r;
  logic [31:0]       y_r;
  logic [4:0]        n_r;
  logic [15:0]       frac_r;

  logic                  out_valid_r;
  logic [1:0]            out_band_r;
  logic [MEAN_W-1:0]     out_mean_r;
  logic signed [DB_W-1:0] out_db_r;
  logic                  out_last_r;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [35:0]       f_full;
  logic [F_W-1:0]    f_val;

  assign f_full = prod_r[47:12];
  assign f_val  = (f_full > 36'(FREQ_MAX)) ? FREQ_MAX : f_full[F_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_FREQ: begin mul_a = MUL_W'(idx_r);          mul_b = hz_i;              end
      MUL_FSQ:  begin mul_a = MUL_W'(f_val);          mul_b = MUL_W'(f_val);     end
      MUL_RBRD: begin mul_a = MUL_W'(rb_r);           mul_b = MUL_W'(rd_r);      end
      MUL_RAS:  begin mul_a = MUL_W'(ra_r);           mul_b = MUL_W'(sq_root_r[RAT_W-1:0]); end
      MUL_GRC:  begin mul_a = MUL_W'(prod_r[40:20]);  mul_b = MUL_W'(rc_r);      end
      MUL_MAGG: begin mul_a = MUL_W'(mag_r);          mul_b = MUL_W'(prod_r[40:20]); end
      MUL_WSQ:  begin mul_a = MUL_W'(wm_r);           mul_b = MUL_W'(wm_r);      end
      MUL_LOG:  begin mul_a = y_r;                    mul_b = y_r;               end
      MUL_DB:   begin mul_a = MUL_W'({n_r, frac_r});  mul_b = MUL_W'(DB_K);      end
      default:  begin mul_a = '0;                     mul_b = '0;                end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (cmd_i.mul_sel != MUL_NONE) begin
      prod_r <= mul_p;
    end
  end

  // band selection at close
  logic [EDGE_W-1:0] lo_e, hi_e;
  logic              beyond;
  logic [SUM_W-1:0]  eff_sum;
  logic [BP_W-1:0]   eff_cnt;

  assign lo_e   = edges_i[cmd_i.band];
  assign hi_e   = edges_i[3'(cmd_i.band) + 3'd1];
  assign beyond = CMP_W'(lo_e) > CMP_W'(fin_r);

  always_comb begin
    eff_sum = sum_r[cmd_i.band];
    eff_cnt = cnt_r[cmd_i.band];
    if (beyond) begin
      if (CMP_W'(hi_e) >= CMP_W'(fin_r)) begin
        eff_sum = SUM_W'(fbp_r);
        eff_cnt = BP_W'(1);
      end else begin
        eff_sum = '0;
        eff_cnt = '0;
      end
    end
  end

  // divider operands
  logic [REM_W-1:0] div_rem;
  logic [DVD_W-1:0] div_shin;
  logic [DEN_W-1:0] div_den;
  logic [5:0]       div_steps;
  logic             div_busy;
  logic [DVD_W-1:0] div_quot;

  always_comb begin
    div_rem   = REM_W'(f2_r);
    div_shin  = '0;
    div_den   = {1'b0, f2_r} + KA2;
    div_steps = RAT_STEPS;
    unique case (cmd_i.div_sel)
      DIV_RA: div_den = {1'b0, f2_r} + KA2;
      DIV_RB: div_den = {1'b0, f2_r} + KB2;
      DIV_RD: div_den = {1'b0, f2_r} + KD2;
      DIV_RC: begin
        div_rem = REM_W'(KC2);
        div_den = {1'b0, f2_r} + KC2;
      end
      DIV_MEAN: begin
        div_rem   = REM_W'(eff_sum[SUM_W-1]);
        div_shin  = {eff_sum[SUM_W-2:0], 1'b0};
        div_den   = DEN_W'(eff_cnt);
        div_steps = MEAN_STEPS;
      end
      default: div_steps = RAT_STEPS;
    endcase
  end

  sbe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .rem_i   (div_rem),
    .shin_i  (div_shin),
    .den_i   (div_den),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd_i.f2_load) begin
      f2_r <= prod_r[F2_W-1:0];
    end
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        DIV_RA:  ra_r <= div_quot[RAT_W-1:0];
        DIV_RB:  rb_r <= div_quot[RAT_W-1:0];
        DIV_RD:  rd_r <= div_quot[RAT_W-1:0];
        DIV_RC:  rc_r <= div_quot[RAT_W-1:0];
        default: ra_r <= ra_r;
      endcase
    end
    if (cmd_i.wm_load) begin
      wm_r <= cmd_i.wm_raw ? mag_r : prod_r[35:20];
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  logic [SQ_W-1:0] sq_t;
  assign sq_t = sq_root_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd_i.sq_start) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_bit_r[0]) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.sq_start) begin
      sq_v_r    <= prod_r[SQ_W-1:0];
      sq_root_r <= '0;
      sq_bit_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (sq_busy_r) begin
      if (sq_v_r >= sq_t) begin
        sq_v_r    <= sq_v_r - sq_t;
        sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // bin capture and accumulation
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      mag_r      <= in_mag_i;
      last_r     <= in_last_i;
      idx_r      <= bin_pos_r[IDX_W-1:0];
      weight_r   <= weighting_i;
      in_range_r <= bin_pos_r < BP_W'(MAX_BINS);
      fin_r      <= (bin_pos_r < BP_W'(MAX_BINS)) ? bin_pos_r[IDX_W-1:0]
                                                  : IDX_W'(MAX_BINS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_pos_r <= '0;
      fbp_r     <= '0;
      for (int b = 0; b < BANDS; b++) begin
        sum_r[b] <= '0;
        cnt_r[b] <= '0;
      end
    end else begin
      if (cmd_i.acc) begin
        bin_pos_r <= bin_pos_r + BP_W'(1);
        fbp_r     <= prod_r[MEAN_W-1:0];
        for (int b = 0; b < BANDS; b++) begin
          if (CMP_W'(edges_i[b]) <= CMP_W'(idx_r) &&
              CMP_W'(idx_r) <= CMP_W'(edges_i[b+1])) begin
            sum_r[b] <= sum_r[b] + SUM_W'(prod_r[MEAN_W-1:0]);
            cnt_r[b] <= cnt_r[b] + BP_W'(1);
          end
        end
      end
      if (cmd_i.emit) begin
        sum_r[cmd_i.band] <= '0;
        cnt_r[cmd_i.band] <= '0;
      end
      if (cmd_i.spec_clear) begin
        bin_pos_r <= '0;
        fbp_r     <= '0;
      end
    end
  end

  // mean, normalize, log2 by repeated squaring
  logic [32:0] ys;
  assign ys = prod_r[63:31];

  always_ff @(posedge clk) begin
    if (cmd_i.mean_clear) begin
      mean_r <= '0;
    end else if (cmd_i.mean_load) begin
      mean_r <= (|div_quot[DVD_W-1:MEAN_W]) ? '1 : div_quot[MEAN_W-1:0];
    end
    if (cmd_i.norm_init) begin
      y_r    <= mean_r;
      n_r    <= 5'd31;
      frac_r <= '0;
    end else if (cmd_i.norm_step) begin
      y_r <= {y_r[30:0], 1'b0};
      n_r <= n_r - 5'd1;
    end else if (cmd_i.log_step) begin
      if (ys[32]) begin
        y_r    <= ys[32:1];
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        y_r    <= ys[31:0];
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
  end

  // dB from the registered log product
  logic [47:0]        db_round;
  logic signed [16:0] db_raw;
  logic signed [16:0] db_val;

  assign db_round = {1'b0, prod_r[46:0]} + 48'h0000_8000_0000;
  assign db_raw   = $signed({1'b0, db_round[47:32]}) - DB_OFFSET;

  always_comb begin
    if (mean_r == '0) begin
      db_val = DB_FLOOR;
    end else if (db_raw < DB_FLOOR) begin
      db_val = DB_FLOOR;
    end else if (db_raw > DB_CEIL) begin
      db_val = DB_CEIL;
    end else begin
      db_val = db_raw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_band_r <= cmd_i.band;
      out_mean_r <= mean_r;
      out_db_r   <= db_val[DB_W-1:0];
      out_last_r <= cmd_i.band == 2'(BANDS - 1);
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_band_o  = out_band_r;
  assign out_mean_o  = out_mean_r;
  assign out_db_o    = out_db_r;
  assign out_last_o  = out_last_r;

  always_comb begin
    st_o.in_range  = in_range_r;
    st_o.weight_en = weight_r;
    st_o.last_bin  = last_r;
    st_o.div_busy  = div_busy;
    st_o.sq_busy   = sq_busy_r;
    st_o.cnt_zero  = eff_cnt == '0;
    st_o.mean_zero = mean_r == '0;
    st_o.y_msb     = y_r[31];
    st_o.out_free  = !out_valid_r || out_ready_i;
  end
endmodule

// ===== rtl/sbe_ctrl.sv =====
`timescale 1ns / 1ps
module sbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  input  sbe_pkg::dp_status_t st_i,
  output logic                in_ready_o,
  output sbe_pkg::ctrl_cmd_t  cmd_o
);
  import sbe_pkg::*;

  ctrl_state_t state_r, state_nxt;
  div_sel_t    dsel_r, dsel_nxt;
  logic [1:0]  band_r, band_nxt;
  logic [3:0]  it_r, it_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dsel_r  <= DIV_RA;
      band_r  <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dsel_r  <= dsel_nxt;
      band_r  <= band_nxt;
      it_r    <= it_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dsel_nxt      = dsel_r;
    band_nxt      = band_r;
    it_nxt        = it_r;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.div_sel = dsel_r;
    cmd_o.band    = band_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!st_i.in_range) begin
          band_nxt  = '0;
          state_nxt = st_i.last_bin ? ST_CSEL : ST_IDLE;
        end else if (st_i.weight_en) begin
          state_nxt = ST_FREQ;
        end else begin
          cmd_o.wm_load = 1'b1;
          cmd_o.wm_raw  = 1'b1;
          state_nxt     = ST_PSQ;
        end
      end
      ST_FREQ: begin
        cmd_o.mul_sel = MUL_FREQ;
        state_nxt     = ST_FSQ;
      end
      ST_FSQ: begin
        cmd_o.mul_sel = MUL_FSQ;
        state_nxt     = ST_F2;
      end
      ST_F2: begin
        cmd_o.f2_load = 1'b1;
        dsel_nxt      = DIV_RA;
        state_nxt     = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          unique case (dsel_r)
            DIV_RA:  begin dsel_nxt = DIV_RB; state_nxt = ST_DSTART; end
            DIV_RB:  begin dsel_nxt = DIV_RD; state_nxt = ST_DSTART; end
            DIV_RD:  begin dsel_nxt = DIV_RC; state_nxt = ST_DSTART; end
            default: state_nxt = ST_SQMUL;
          endcase
        end
      end
      ST_SQMUL: begin
        cmd_o.mul_sel = MUL_RBRD;
        state_nxt     = ST_SQSTART;
      end
      ST_SQSTART: begin
        cmd_o.sq_start = 1'b1;
        state_nxt      = ST_SQWAIT;
      end
      ST_SQWAIT: begin
        if (!st_i.sq_busy) begin
          state_nxt = ST_G1;
        end
      end
      ST_G1: begin
        cmd_o.mul_sel = MUL_RAS;
        state_nxt     = ST_G2;
      end
      ST_G2: begin
        cmd_o.mul_sel = MUL_GRC;
        state_nxt     = ST_G3;
      end
      ST_G3: begin
        cmd_o.mul_sel = MUL_MAGG;
        state_nxt     = ST_WSEL;
      end
      ST_WSEL: begin
        cmd_o.wm_load = 1'b1;
        state_nxt     = ST_PSQ;
      end
      ST_PSQ: begin
        cmd_o.mul_sel = MUL_WSQ;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        band_nxt  = '0;
        state_nxt = st_i.last_bin ? ST_CSEL : ST_IDLE;
      end
      ST_CSEL: begin
        cmd_o.div_sel = DIV_MEAN;
        if (st_i.cnt_zero) begin
          cmd_o.mean_clear = 1'b1;
          state_nxt        = ST_NINIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_nxt       = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        cmd_o.div_sel = DIV_MEAN;
        if (!st_i.div_busy) begin
          cmd_o.mean_load = 1'b1;
          state_nxt       = ST_NINIT;
        end
      end
      ST_NINIT: begin
        cmd_o.norm_init = 1'b1;
        state_nxt       = st_i.mean_zero ? ST_EMIT : ST_NORM;
      end
      ST_NORM: begin
        if (st_i.y_msb) begin
          it_nxt    = '0;
          state_nxt = ST_LSQ;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      ST_LSQ: begin
        cmd_o.mul_sel = MUL_LOG;
        state_nxt     = ST_LUPD;
      end
      ST_LUPD: begin
        cmd_o.log_step = 1'b1;
        it_nxt         = it_r + 4'd1;
        state_nxt      = (it_r == 4'd15) ? ST_DBMUL : ST_LSQ;
      end
      ST_DBMUL: begin
        cmd_o.mul_sel = MUL_DB;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (band_r == 2'(BANDS - 1)) begin
            cmd_o.spec_clear = 1'b1;
            state_nxt        = ST_IDLE;
          end else begin
            band_nxt  = band_r + 2'd1;
            state_nxt = ST_CSEL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/spectrum_band_energy_unit.sv =====
`timescale 1ns / 1ps
// Unweighted bins go straight to squaring and summing; with A-weighting each bin's gain
// first needs the shared restoring divider (four ratios, in turn) and the square root.
// Bins are taken one at a time; the next is accepted once the last is summed or dropped,
// and after a closing bin once the spectrum is closed: per band a mean division, normalize
// and 16 squaring steps; the four results leave through one output register.
// Reset (synchronous, rst_n low) loads the register defaults and clears all sums.
module spectrum_band_energy_unit #(
  parameter int MAX_BINS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  sbe_in_if.sink      in_bin,
  sbe_out_if.source   out_band,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbe_pkg::*;
`include "spectrum_band_energy_unit_macros.svh"

  logic [EDGES-1:0][EDGE_W-1:0] edges_r;
  logic                         weight_r;
  logic [HZ_W-1:0]              hz_r;
  reg_idx_t                     reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edges_r[0] <= 12'd0;
      edges_r[1] <= 12'd5;
      edges_r[2] <= 12'd46;
      edges_r[3] <= 12'd185;
      edges_r[4] <= 12'd464;
      weight_r   <= 1'b0;
      hz_r       <= 32'd2826240;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_EDGE_LOW:      edges_r[0] <= pwdata[EDGE_W-1:0];
        REG_EDGE_LOW_MID:  edges_r[1] <= pwdata[EDGE_W-1:0];
        REG_EDGE_MID_HIGH: edges_r[2] <= pwdata[EDGE_W-1:0];
        REG_EDGE_HIGH:     edges_r[3] <= pwdata[EDGE_W-1:0];
        REG_EDGE_TOP:      edges_r[4] <= pwdata[EDGE_W-1:0];
        REG_WEIGHTING_ON:  weight_r   <= pwdata[0];
        REG_HZ_PER_BIN:    hz_r       <= pwdata;
        default:           hz_r       <= hz_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EDGE_LOW:      prdata = 32'(edges_r[0]);
      REG_EDGE_LOW_MID:  prdata = 32'(edges_r[1]);
      REG_EDGE_MID_HIGH: prdata = 32'(edges_r[2]);
      REG_EDGE_HIGH:     prdata = 32'(edges_r[3]);
      REG_EDGE_TOP:      prdata = 32'(edges_r[4]);
      REG_WEIGHTING_ON:  prdata = 32'(weight_r);
      REG_HZ_PER_BIN:    prdata = hz_r;
      default:           prdata = '0;
    endcase
  end

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_ready;
  logic       in_acc;
  logic       out_valid;
  logic [1:0] out_idx;
  logic       out_last;

  assign in_bin.ready = in_ready;
  assign in_acc       = in_bin.valid && in_ready;

  sbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_bin.valid),
    .st_i       (st),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  sbe_dp #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_mag_i    (in_bin.magnitude),
    .in_last_i   (in_bin.last_bin),
    .edges_i     (edges_r),
    .weighting_i (weight_r),
    .hz_i        (hz_r),
    .out_valid_o (out_valid),
    .out_ready_i (out_band.ready),
    .out_band_o  (out_idx),
    .out_mean_o  (out_band.mean_power),
    .out_db_o    (out_band.power_db),
    .out_last_o  (out_last)
  );

  assign out_band.valid      = out_valid;
  assign out_band.band_index = out_idx;
  assign out_band.last_band  = out_last;

  `SBE_ASSERT_NEXT(a_one_bin_at_a_time, in_acc, !in_ready)
  `SBE_ASSERT_IMP(a_emit_has_room, cmd.emit, st.out_free)
  `SBE_ASSERT_IMP(a_div_idle_at_start, cmd.div_start, !st.div_busy)
  `SBE_ASSERT_IMP(a_last_band_is_top, out_valid && out_last, out_idx == 2'd3)
endmodule

// ===== test/spectrum_band_energy_unit_tb.sv =====
`timescale 1ns / 1ps
module spectrum_band_energy_unit_tb;
  import sbe_pkg::*;

  localparam int BIN_LIMIT = 4096;
  localparam int REG_UNUSED = 7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [1:0]  band;
    logic [31:0] mean;
    logic signed [15:0] db;
    logic        last;
  } band_res_t;

  typedef struct {
    bit          weight;
    logic [15:0] mag;
    logic        last;
    bit          typed;
    logic [31:0] mean;
    logic signed [15:0] db;
  } bin_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  sbe_in_if  bin_if ();
  sbe_out_if band_if ();

  spectrum_band_energy_unit dut (
    .clk(clk), .rst_n(rst_n), .in_bin(bin_if), .out_band(band_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // register mirror and band accumulator state
  logic [11:0] edge_r [5];
  bit          weight_r;
  logic [31:0] hz_r;
  int unsigned bin_pos;
  bit [63:0]   acc_sum [4];
  int unsigned acc_cnt [4];
  bit [31:0]   fin_pow;

  band_res_t band_results_q [$];
  int errors = 0;
  int cycles = 0;
  int n_bins = 0;
  bit calm = 0;
  int stall_left = 0;

  initial begin
    bin_if.valid = 0;
    bin_if.magnitude = '0;
    bin_if.last_bin = 0;
    band_if.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spectrum_band_energy_unit_tb: done, errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      band_if.ready <= 0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      band_if.ready <= 0;
    end else begin
      band_if.ready <= 1;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s at %0t", msg, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    band_res_t e;
    if (rst_n && band_if.valid && band_if.ready) begin
      if (band_results_q.size() == 0) begin
        report_mismatch("band result with nothing pending");
      end else begin
        e = band_results_q.pop_front();
        if (band_if.band_index !== e.band)
          report_mismatch($sformatf("band_index got %0d exp %0d", band_if.band_index, e.band));
        if (band_if.mean_power !== e.mean)
          report_mismatch($sformatf("band %0d mean_power got %0h exp %0h",
                                    e.band, band_if.mean_power, e.mean));
        if (band_if.power_db !== e.db)
          report_mismatch($sformatf("band %0d power_db got %0d exp %0d",
                                    e.band, band_if.power_db, e.db));
        if (band_if.last_band !== e.last)
          report_mismatch($sformatf("band %0d last_band got %0b", e.band, band_if.last_band));
      end
    end
  end

  function automatic bit [63:0] isqrt64(input bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] q20_ratio(input bit [63:0] n, input bit [63:0] d);
    return (n << 20) / d;
  endfunction

  function automatic bit [63:0] a_weight_gain(input int unsigned idx);
    bit [63:0] f, f2, ra, rb, rd, rc, s;
    f = (64'(idx) * 64'(hz_r)) >> 12;
    if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
    f2 = f * f;
    ra = q20_ratio(f2, f2 + 64'(KA2));
    rb = q20_ratio(f2, f2 + 64'(KB2));
    rd = q20_ratio(f2, f2 + 64'(KD2));
    rc = q20_ratio(64'(KC2), f2 + 64'(KC2));
    s = isqrt64(rb * rd);
    return (((ra * s) >> 20) * rc) >> 20;
  endfunction

  function automatic bit [31:0] log2_q16(input bit [31:0] x);
    int n;
    bit [31:0] frac;
    bit [63:0] y;
    n = 31;
    frac = 0;
    while (x[n] == 1'b0) n--;
    y = 64'(x) << (31 - n);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        y >>= 1;
      end
    end
    return (32'(n) << 16) | frac;
  endfunction

  function automatic logic signed [15:0] power_db_of(input bit [31:0] mp);
    bit [63:0] t;
    int d;
    if (mp == 0) return 16'(int'(DB_FLOOR));
    t = 64'(log2_q16(mp)) * 64'(DB_K);
    d = int'((t + 64'h8000_0000) >> 32) - int'(DB_OFFSET);
    if (d < int'(DB_FLOOR)) d = int'(DB_FLOOR);
    if (d > int'(DB_CEIL)) d = int'(DB_CEIL);
    return 16'(d);
  endfunction

  // accumulate one accepted bin; on the closing bin queue the four band results
  task automatic accumulate_bin(input logic [15:0] mag, input logic last);
    int unsigned idx, fin, cnt, lo, hi;
    bit [63:0] wm, sum, mean;
    bit [31:0] p;
    band_res_t r;
    idx = bin_pos;
    if (idx < BIN_LIMIT) begin
      wm = 64'(mag);
      if (weight_r) wm = (wm * a_weight_gain(idx)) >> 20;
      p = 32'(wm * wm);
      for (int b = 0; b < 4; b++)
        if (edge_r[b] <= idx && idx <= edge_r[b+1]) begin
          acc_sum[b] += 64'(p);
          acc_cnt[b]++;
        end
      fin_pow = p;
      bin_pos = idx + 1;
    end
    if (last) begin
      fin = (idx < BIN_LIMIT) ? idx : BIN_LIMIT - 1;
      for (int b = 0; b < 4; b++) begin
        lo = edge_r[b];
        hi = edge_r[b+1];
        sum = acc_sum[b];
        cnt = acc_cnt[b];
        mean = 0;
        // band starting past the final bin: final bin alone, or nothing
        if (lo > fin) begin
          if (hi >= fin) begin
            sum = 64'(fin_pow);
            cnt = 1;
          end else begin
            sum = 0;
            cnt = 0;
          end
        end
        if (cnt != 0) mean = sum / cnt;
        if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
        r.band = 2'(b);
        r.mean = 32'(mean);
        r.db = power_db_of(32'(mean));
        r.last = (b == 3);
        band_results_q.push_back(r);
        acc_sum[b] = 0;
        acc_cnt[b] = 0;
      end
      bin_pos = 0;
      fin_pow = 0;
    end
  endtask

  task automatic send_bin(input logic [15:0] mag, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      bin_if.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    bin_if.valid <= 1;
    bin_if.magnitude <= mag;
    bin_if.last_bin <= last;
    do @(posedge clk); while (!bin_if.ready);
    accumulate_bin(mag, last);
    n_bins++;
  endtask

  task automatic drain_bands();
    bin_if.valid <= 0;
    while (band_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx <= REG_EDGE_TOP) edge_r[idx] = val[11:0];
    else if (idx == REG_WEIGHTING_ON) weight_r = val[0];
    else if (idx == REG_HZ_PER_BIN) hz_r = val;
  endtask

  task automatic write_edges(input int e0, input int e1, input int e2, input int e3,
                             input int e4);
    write_reg(REG_EDGE_LOW, e0);
    write_reg(REG_EDGE_LOW_MID, e1);
    write_reg(REG_EDGE_MID_HIGH, e2);
    write_reg(REG_EDGE_HIGH, e3);
    write_reg(REG_EDGE_TOP, e4);
  endtask

  function automatic int pick_edge();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 30);
  endfunction

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_hz();
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd2826240;
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  bin_row_t dir_rows [] = '{
    '{0, 16'h0000, 1, 1, 32'h0, -16'sd25600},
    '{0, 16'hFFFF, 1, 0, 32'h0, 16'sd0},
    '{0, 16'h0100, 0, 0, 32'h0, 16'sd0},
    '{0, 16'h8000, 0, 0, 32'h0, 16'sd0},
    '{0, 16'hFFFF, 0, 0, 32'h0, 16'sd0},
    '{0, 16'h0001, 0, 0, 32'h0, 16'sd0},
    '{0, 16'h7FFF, 0, 0, 32'h0, 16'sd0},
    '{0, 16'h0000, 0, 0, 32'h0, 16'sd0},
    '{0, 16'h00FF, 0, 0, 32'h0, 16'sd0},
    '{0, 16'hFF00, 1, 0, 32'h0, 16'sd0},
    // weighting gain at bin zero is zero
    '{1, 16'hFFFF, 1, 1, 32'h0, -16'sd25600},
    '{1, 16'h1234, 0, 0, 32'h0, 16'sd0},
    '{1, 16'hFFFF, 0, 0, 32'h0, 16'sd0},
    '{1, 16'h8001, 0, 0, 32'h0, 16'sd0},
    '{1, 16'h5555, 0, 0, 32'h0, 16'sd0},
    '{1, 16'hAAAA, 1, 0, 32'h0, 16'sd0}
  };

  initial begin
    int len, total;
    edge_r = '{12'd0, 12'd5, 12'd46, 12'd185, 12'd464};
    weight_r = 0;
    hz_r = 32'd2826240;
    bin_pos = 0;
    fin_pow = 0;
    for (int b = 0; b < 4; b++) begin
      acc_sum[b] = 0;
      acc_cnt[b] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].weight != weight_r) begin
        drain_bands();
        write_reg(REG_WEIGHTING_ON, 32'(dir_rows[i].weight));
      end
      send_bin(dir_rows[i].mag, dir_rows[i].last);
      if (dir_rows[i].typed)
        for (int k = band_results_q.size() - 4; k < band_results_q.size(); k++) begin
          band_results_q[k].mean = dir_rows[i].mean;
          band_results_q[k].db = dir_rows[i].db;
        end
    end

    // empty band (edge below the one before) and an ignored register index
    drain_bands();
    write_edges(0, 10, 3, 6, 8);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) send_bin(pick_mag(), i == 8);

    // edge and bin-width extremes with weighting
    drain_bands();
    write_edges(0, 4095, 0, 4095, 0);
    write_reg(REG_HZ_PER_BIN, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) send_bin(pick_mag(), i == 4);
    drain_bands();
    write_reg(REG_HZ_PER_BIN, 32'd1);
    write_edges(4095, 4095, 4095, 4095, 4095);
    for (int i = 0; i < 4; i++) send_bin(pick_mag(), i == 3);

    total = 0;
    while (n_bins < 170) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_bands();
        write_edges(pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge());
        write_reg(REG_WEIGHTING_ON, $urandom_range(0, 1));
        write_reg(REG_HZ_PER_BIN, pick_hz());
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 20);
      if (n_bins >= 145) calm = 1;
      for (int i = 0; i < len; i++) send_bin(pick_mag(), i == len - 1);
      if (total < 50 && total + len >= 50) begin
        bin_if.valid <= 0;
        while (band_results_q.size() != 0) @(posedge clk);
      end
      total += len;
    end

    drain_bands();
    if (errors == 0) begin
      $display("spectrum_band_energy_unit_tb: done, clean");
    end else begin
      $display("spectrum_band_energy_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbe_pkg.sv
rtl/sbe_if.sv
rtl/sbe_div.sv
rtl/sbe_dp.sv
rtl/sbe_ctrl.sv
rtl/spectrum_band_energy_unit.sv
test/spectrum_band_energy_unit_tb.sv
